/* sv/auto_joypad_reader_core_macros.svh */
// assertion macros for the auto joypad reader core
`ifndef AUTO_JOYPAD_READER_CORE_MACROS_SVH
`define AUTO_JOYPAD_READER_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define AJR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ajr check failed");

// next-cycle implication, checked out of reset
`define AJR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ajr check failed");

`endif

/* sv/ajr_pkg.sv */
// types and constants shared by the auto joypad reader files
`default_nettype none
package ajr_pkg;

    localparam int GAP_W  = 16;
    localparam int STEP_W = 6;
    localparam int PAD_W  = 16;
    localparam int NPADS  = 4;

    localparam logic [GAP_W-1:0]  STEP_GAP_RESET = 16'd124;
    localparam logic [STEP_W-1:0] LATCH_STEP     = 6'd1;
    localparam logic [STEP_W-1:0] LAST_STEP      = 6'd33;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_VBLANK   = 3'd1,
        ACT_WR_EN    = 3'd2,
        ACT_RD_STAT  = 3'd3,
        ACT_RD_PAD   = 3'd4
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] bus_value;
        logic [2:0] data_index;
        logic [1:0] port1_bits;
        logic [1:0] port2_bits;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       latch_write;
        logic       latch_level;
        logic       port1_clock;
        logic       port2_clock;
        logic       busy_res;
    } t_out_word;

endpackage
`default_nettype wire

/* sv/ajr_in_if.sv */
// input word channel of the auto joypad reader
`default_nettype none
interface ajr_in_if;
    import ajr_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/ajr_out_if.sv */
// result word channel of the auto joypad reader
`default_nettype none
interface ajr_out_if;
    import ajr_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/auto_joypad_reader_core.sv */
// auto joypad reader: vblank-triggered latch and serial pad read sequencer
//
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    action, bus_value, data_index, port bits
//  o_out     out  valid/ready    read byte, latch strobes, port clocks, busy
//  i_cfg_*   in   write enable   step_gap (16 bit)
//
// one word per cycle sustained while o_out keeps taking results; each word passes
// through the input register and then the result register
// synchronous active-low reset clears the enable, the sequencer, the pad words
// and both valid flags; step_gap returns to 124
// a stall on o_out holds the result register and backs up into the input
// register; i_in.ready drops only when both stages are full and stalled
`default_nettype none
`include "auto_joypad_reader_core_macros.svh"
module auto_joypad_reader_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ajr_pkg::GAP_W-1:0]   i_cfg_wdata,
    ajr_in_if.sink                      i_in,
    ajr_out_if.source                   o_out
);
    import ajr_pkg::*;

    // pipeline registers
    logic       r_in_valid;
    t_in_word   r_in;
    logic       r_out_valid;
    t_out_word  r_out;
    t_out_word  n_out;

    // config and sequencer state
    logic [GAP_W-1:0]  r_step_gap;
    logic              r_auto_en,  n_auto_en;
    logic              r_reading,  n_reading;
    logic [STEP_W-1:0] r_step_idx, n_step_idx;
    logic [GAP_W-1:0]  r_gap_cnt,  n_gap_cnt;
    logic [PAD_W-1:0]  r_pad [NPADS];
    logic [PAD_W-1:0]  n_pad [NPADS];

    logic              w_out_free;
    logic              w_adv;
    logic [GAP_W-1:0]  w_gap_inc;
    logic [STEP_W-1:0] w_step_inc;
    logic [PAD_W-1:0]  w_pad_sel;

    // handshake: the result register empties or is being taken this cycle
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_out_free;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_gap_inc  = r_gap_cnt + GAP_W'(1);
    assign w_step_inc = r_step_idx + STEP_W'(1);
    assign w_pad_sel  = r_pad[r_in.data_index[2:1]];

    // one pass of the sequencer for the word in the input register
    always_comb begin
        n_auto_en  = r_auto_en;
        n_reading  = r_reading;
        n_step_idx = r_step_idx;
        n_gap_cnt  = r_gap_cnt;
        for (int k = 0; k < NPADS; k++) begin
            n_pad[k] = r_pad[k];
        end
        n_out = '0;

        unique case (r_in.action)
            ACT_TICK: begin
                if (r_reading) begin
                    n_gap_cnt = w_gap_inc;
                    // action due: gap reached (a gap of zero fires every tick)
                    if (w_gap_inc >= r_step_gap) begin
                        n_gap_cnt  = '0;
                        n_step_idx = w_step_inc;
                        if (w_step_inc == LATCH_STEP) begin
                            // first action drops the latch
                            n_out.latch_write = 1'b1;
                        end else if (!w_step_inc[0]) begin
                            // even steps clock port 1 into words 0 and 2
                            n_out.port1_clock = 1'b1;
                            n_pad[0] = {r_pad[0][PAD_W-2:0], r_in.port1_bits[0]};
                            n_pad[2] = {r_pad[2][PAD_W-2:0], r_in.port1_bits[1]};
                        end else begin
                            // odd steps clock port 2 into words 1 and 3
                            n_out.port2_clock = 1'b1;
                            n_pad[1] = {r_pad[1][PAD_W-2:0], r_in.port2_bits[0]};
                            n_pad[3] = {r_pad[3][PAD_W-2:0], r_in.port2_bits[1]};
                            if (w_step_inc >= LAST_STEP) begin
                                n_reading = 1'b0;
                            end
                        end
                    end
                end
            end
            ACT_VBLANK: begin
                // when enabled, start or restart the sequence with the latch high
                if (r_auto_en) begin
                    n_reading         = 1'b1;
                    n_step_idx        = '0;
                    n_gap_cnt         = '0;
                    n_out.latch_write = 1'b1;
                    n_out.latch_level = 1'b1;
                end
            end
            ACT_WR_EN: begin
                // clearing the enable aborts a read in flight
                n_auto_en = r_in.bus_value[0];
                if (!r_in.bus_value[0]) begin
                    n_reading = 1'b0;
                end
            end
            ACT_RD_STAT: begin
                n_out.read_byte = {r_in.bus_value[7:1], r_reading};
            end
            ACT_RD_PAD: begin
                n_out.read_byte = r_in.data_index[0] ? w_pad_sel[15:8] : w_pad_sel[7:0];
            end
            default: begin
                // undefined action codes leave everything alone
            end
        endcase

        n_out.busy_res = n_reading;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    // step gap register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_gap <= STEP_GAP_RESET;
        end else if (i_cfg_we) begin
            r_step_gap <= i_cfg_wdata;
        end
    end

    // sequencer state and pad words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto_en  <= 1'b0;
            r_reading  <= 1'b0;
            r_step_idx <= '0;
            r_gap_cnt  <= '0;
            for (int k = 0; k < NPADS; k++) begin
                r_pad[k] <= '0;
            end
        end else if (w_adv) begin
            r_auto_en  <= n_auto_en;
            r_reading  <= n_reading;
            r_step_idx <= n_step_idx;
            r_gap_cnt  <= n_gap_cnt;
            for (int k = 0; k < NPADS; k++) begin
                r_pad[k] <= n_pad[k];
            end
        end
    end

    // checks
    `AJR_ASSERT_SAME(a_step_in_range, i_clk, i_rst_n, r_reading, r_step_idx <= LAST_STEP)
    `AJR_ASSERT_SAME(a_one_strobe, i_clk, i_rst_n, r_out_valid, $onehot0({r_out.latch_write, r_out.port1_clock, r_out.port2_clock}))
    `AJR_ASSERT_SAME(a_latch_hi_busy, i_clk, i_rst_n, r_out_valid && r_out.latch_level, r_out.busy_res && r_out.latch_write)
    `AJR_ASSERT_NEXT(a_disable_aborts, i_clk, i_rst_n, w_adv && r_in.action == ACT_WR_EN && !r_in.bus_value[0], !r_reading && !r_auto_en)

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
// self-checking testbench for the auto joypad reader core
`default_nettype none
module tb;
    import ajr_pkg::*;

    // action codes the block ignores
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    // settle time after the pipeline drains, before the gap register is written
    localparam int SETTLE_CYCLES = 4;
    // receiver hold-off long enough to fill both stages and stall the input
    localparam int LONG_HOLD     = 80;
    // words per random phase, five phases in all
    localparam int PHASE_WORDS   = 200;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // everything the block sees comes from these registers, known from time zero
    logic             cfg_we_r    = 1'b0;
    logic [GAP_W-1:0] cfg_wdata_r = '0;
    logic             in_valid_r  = 1'b0;
    t_in_word         in_word_r   = '0;
    logic             out_ready_r = 1'b0;

    ajr_in_if  cpu_bus ();
    ajr_out_if res_bus ();

    assign cpu_bus.valid = in_valid_r;
    assign cpu_bus.data  = in_word_r;
    assign res_bus.ready = out_ready_r;

    auto_joypad_reader_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we_r),
        .i_cfg_wdata (cfg_wdata_r),
        .i_in        (cpu_bus),
        .o_out       (res_bus)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // bus words waiting to be offered, and the results they are predicted to give
    t_in_word  cpu_words[$];
    t_out_word predicted_words[$];

    int  mismatches = 0;
    int  stim_count = 0;
    // handshakes seen at the last rising edge, consumed at the next falling edge
    bit  in_taken   = 1'b0;
    bit  out_taken  = 1'b0;

    // idle bookkeeping for both sides
    int  src_wait   = 0;
    int  src_burst  = 0;
    int  sink_wait  = 0;
    int  sink_burst = 0;
    int  sink_hold  = 0;
    bit  hold_arm   = 1'b0;
    bit  hold_done  = 1'b0;

    // shadow of the poller state
    logic [GAP_W-1:0]  gap_shadow = STEP_GAP_RESET;
    logic              en_shadow  = 1'b0;
    logic              seq_busy   = 1'b0;
    logic [STEP_W-1:0] seq_step   = '0;
    logic [GAP_W-1:0]  seq_ticks  = '0;
    logic [PAD_W-1:0]  pad_shadow [NPADS];

    initial begin
        for (int i = 0; i < NPADS; i++) pad_shadow[i] = '0;
    end

    // one bus word in, one result word out; updates the shadow state
    function automatic t_out_word poll_predict(input t_in_word w);
        t_out_word         r;
        logic [STEP_W-1:0] n;
        logic [PAD_W-1:0]  pw;
        r = '0;
        case (w.action)
            ACT_TICK: begin
                if (seq_busy) begin
                    seq_ticks = seq_ticks + 1'b1;
                    // a gap of zero fires on every tick, same as a gap of one
                    if (seq_ticks >= gap_shadow) begin
                        seq_ticks = '0;
                        seq_step  = seq_step + 1'b1;
                        n         = seq_step;
                        if (n == LATCH_STEP) begin
                            // latch goes low, level stays 0
                            r.latch_write = 1'b1;
                        end else if (!n[0]) begin
                            // even steps clock port 1: bit0 to word 0, bit1 to word 2
                            r.port1_clock = 1'b1;
                            pad_shadow[0] = {pad_shadow[0][PAD_W-2:0], w.port1_bits[0]};
                            pad_shadow[2] = {pad_shadow[2][PAD_W-2:0], w.port1_bits[1]};
                        end else begin
                            // odd steps clock port 2: bit0 to word 1, bit1 to word 3
                            r.port2_clock = 1'b1;
                            pad_shadow[1] = {pad_shadow[1][PAD_W-2:0], w.port2_bits[0]};
                            pad_shadow[3] = {pad_shadow[3][PAD_W-2:0], w.port2_bits[1]};
                            if (n >= LAST_STEP) seq_busy = 1'b0;
                        end
                    end
                end
            end
            ACT_VBLANK: begin
                // ignored while disabled; restarts from latch-high while busy
                if (en_shadow) begin
                    seq_busy      = 1'b1;
                    seq_step      = '0;
                    seq_ticks     = '0;
                    r.latch_write = 1'b1;
                    r.latch_level = 1'b1;
                end
            end
            ACT_WR_EN: begin
                // clearing the enable aborts; setting it never resumes
                en_shadow = w.bus_value[0];
                if (!en_shadow) seq_busy = 1'b0;
            end
            ACT_RD_STAT: begin
                r.read_byte = {w.bus_value[7:1], seq_busy};
            end
            ACT_RD_PAD: begin
                pw          = pad_shadow[w.data_index[2:1]];
                r.read_byte = w.data_index[0] ? pw[15:8] : pw[7:0];
            end
            default: begin
                // spare codes leave the state alone
            end
        endcase
        r.busy_res = seq_busy;
        return r;
    endfunction

    function automatic void cmp_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // idle cycles for the next word, with occasional runs of back-to-back words
    function automatic int pick_idle(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 3);
    endfunction

    // monitor: check results first, then predict the word just accepted
    always @(posedge i_clk) begin : mon_proc
        t_out_word want;
        t_out_word got;
        in_taken  = 1'b0;
        out_taken = 1'b0;
        if (i_rst_n) begin
            if (res_bus.valid === 1'b1 && out_ready_r) begin
                out_taken = 1'b1;
                got       = res_bus.data;
                if (predicted_words.size() == 0) begin
                    $display("%0t: result word with none expected, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = predicted_words.pop_front();
                    cmp_field("read_byte", want.read_byte, got.read_byte);
                    cmp_field("latch_write", {7'd0, want.latch_write}, {7'd0, got.latch_write});
                    cmp_field("latch_level", {7'd0, want.latch_level}, {7'd0, got.latch_level});
                    cmp_field("port1_clock", {7'd0, want.port1_clock}, {7'd0, got.port1_clock});
                    cmp_field("port2_clock", {7'd0, want.port2_clock}, {7'd0, got.port2_clock});
                    cmp_field("busy_res", {7'd0, want.busy_res}, {7'd0, got.busy_res});
                end
            end
            if (in_valid_r && cpu_bus.ready === 1'b1) begin
                in_taken = 1'b1;
                predicted_words.push_back(poll_predict(in_word_r));
            end
        end
    end

    // driver: offers queued words, drawing an idle gap after each one taken
    always @(negedge i_clk) begin : drv_proc
        logic     nv;
        t_in_word nd;
        nv = in_valid_r;
        nd = in_word_r;
        if (in_valid_r && in_taken) begin
            nv       = 1'b0;
            src_wait = pick_idle(src_burst);
        end
        if (!nv && i_rst_n) begin
            if (src_wait != 0) begin
                src_wait--;
            end else if (cpu_words.size() != 0) begin
                nd = cpu_words.pop_front();
                nv = 1'b1;
            end
        end
        // single update per edge so valid never glitches between words
        in_valid_r <= nv;
        in_word_r  <= nd;
    end

    // receiver: random stalls per word, plus one long hold-off when armed
    always @(negedge i_clk) begin : snk_proc
        logic nr;
        nr = 1'b0;
        if (i_rst_n) begin
            if (out_taken) sink_wait = pick_idle(sink_burst);
            if (hold_arm && !hold_done && out_taken) begin
                sink_hold = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (sink_hold != 0) begin
                sink_hold--;
            end else if (sink_wait != 0) begin
                sink_wait--;
            end else begin
                nr = 1'b1;
            end
        end
        out_ready_r <= nr;
    end

    function automatic t_in_word rand_word(input logic [2:0] act);
        t_in_word w;
        w.action     = t_action'(act);
        w.bus_value  = 8'($urandom_range(0, 255));
        w.data_index = 3'($urandom_range(0, 7));
        w.port1_bits = 2'($urandom_range(0, 3));
        w.port2_bits = 2'($urandom_range(0, 3));
        return w;
    endfunction

    function automatic t_in_word bus_word(input logic [2:0] act, input logic [7:0] bus,
                                          input logic [2:0] idx, input logic [1:0] p1,
                                          input logic [1:0] p2);
        t_in_word w;
        w.action     = t_action'(act);
        w.bus_value  = bus;
        w.data_index = idx;
        w.port1_bits = p1;
        w.port2_bits = p2;
        return w;
    endfunction

    task automatic push_word(input t_in_word w);
        cpu_words.push_back(w);
        stim_count++;
    endtask

    // nothing queued, nothing on the bus, nothing outstanding; checked at the
    // rising edge where the driver's outputs are settled
    task automatic wait_drained();
        @(posedge i_clk);
        while (cpu_words.size() != 0 || in_valid_r || predicted_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_gap(input logic [GAP_W-1:0] g);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we_r    <= 1'b1;
        cfg_wdata_r <= g;
        gap_shadow   = g;
        @(negedge i_clk);
        cfg_we_r    <= 1'b0;
    endtask

    // one vblank poll: enable, vblank, enough ticks to finish, then read all pads;
    // a quarter of the runs get broken by an abort or a restart partway through
    task automatic queue_poll_run(input int g);
        t_in_word w;
        int       ticks_left;
        int       break_at;
        int       pick;
        ticks_left = 33 * ((g == 0) ? 1 : g) + $urandom_range(0, 3);
        break_at   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, ticks_left) : -1;
        w = rand_word(ACT_WR_EN);
        w.bus_value[0] = 1'b1;
        push_word(w);
        push_word(rand_word(ACT_VBLANK));
        while (ticks_left > 0) begin
            if (ticks_left == break_at) begin
                if ($urandom_range(0, 1) == 0) begin
                    // abort by clearing the enable, then re-enable: must not resume
                    w = rand_word(ACT_WR_EN);
                    w.bus_value[0] = 1'b0;
                    push_word(w);
                    w = rand_word(ACT_WR_EN);
                    w.bus_value[0] = 1'b1;
                    push_word(w);
                end else begin
                    push_word(rand_word(ACT_VBLANK));
                end
                break_at = -1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 82) begin
                push_word(rand_word(ACT_TICK));
                ticks_left--;
            end else if (pick < 90) begin
                push_word(rand_word(ACT_RD_PAD));
            end else if (pick < 98) begin
                push_word(rand_word(ACT_RD_STAT));
            end else begin
                push_word(rand_word(3'($urandom_range(ACT_SPARE_A, ACT_SPARE_C))));
            end
        end
        for (int i = 0; i < 2 * NPADS; i++) begin
            w = rand_word(ACT_RD_PAD);
            w.data_index = 3'(i);
            push_word(w);
        end
        push_word(rand_word(ACT_RD_STAT));
    endtask

    initial begin : main_proc
        int g;
        int target;
        bit paused;
        paused = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset gap: reads while idle, spare codes, enable and abort paths
        push_word(bus_word(ACT_RD_STAT, 8'hFF, 3'd0, 2'd0, 2'd0));
        push_word(bus_word(ACT_RD_STAT, 8'h00, 3'd7, 2'd3, 2'd3));
        push_word(bus_word(ACT_RD_PAD, 8'h00, 3'd0, 2'd0, 2'd0));
        push_word(bus_word(ACT_RD_PAD, 8'hFF, 3'd7, 2'd3, 2'd3));
        // vblank while disabled does nothing
        push_word(bus_word(ACT_VBLANK, 8'hFF, 3'd0, 2'd0, 2'd0));
        push_word(bus_word(ACT_TICK, 8'h00, 3'd0, 2'd3, 2'd3));
        push_word(bus_word(ACT_SPARE_A, 8'hFF, 3'd7, 2'd3, 2'd3));
        push_word(bus_word(ACT_SPARE_B, 8'hFF, 3'd7, 2'd3, 2'd3));
        push_word(bus_word(ACT_SPARE_C, 8'hFF, 3'd7, 2'd3, 2'd3));
        push_word(bus_word(ACT_WR_EN, 8'hFF, 3'd0, 2'd0, 2'd0));
        push_word(bus_word(ACT_VBLANK, 8'h00, 3'd0, 2'd0, 2'd0));
        push_word(bus_word(ACT_TICK, 8'h00, 3'd0, 2'd1, 2'd2));
        push_word(bus_word(ACT_RD_STAT, 8'h55, 3'd0, 2'd0, 2'd0));
        // vblank while busy restarts the sequence
        push_word(bus_word(ACT_VBLANK, 8'h00, 3'd0, 2'd0, 2'd0));
        // disable aborts, re-enable does not resume
        push_word(bus_word(ACT_WR_EN, 8'hFE, 3'd0, 2'd0, 2'd0));
        push_word(bus_word(ACT_RD_STAT, 8'h00, 3'd0, 2'd0, 2'd0));
        push_word(bus_word(ACT_WR_EN, 8'h01, 3'd0, 2'd0, 2'd0));
        push_word(bus_word(ACT_TICK, 8'h00, 3'd0, 2'd0, 2'd0));
        push_word(bus_word(ACT_RD_STAT, 8'hAA, 3'd0, 2'd0, 2'd0));

        // widest gap: sequence starts but no action fires in this short stretch
        write_gap(16'hFFFF);
        push_word(bus_word(ACT_WR_EN, 8'h01, 3'd0, 2'd0, 2'd0));
        push_word(bus_word(ACT_VBLANK, 8'h00, 3'd0, 2'd0, 2'd0));
        push_word(bus_word(ACT_TICK, 8'h00, 3'd0, 2'd3, 2'd3));
        push_word(bus_word(ACT_TICK, 8'h00, 3'd0, 2'd3, 2'd3));
        push_word(bus_word(ACT_RD_STAT, 8'hFE, 3'd0, 2'd0, 2'd0));

        // random phases: gap zero, gap one, then small gaps
        for (int ph = 0; ph < 5; ph++) begin
            g = (ph < 4) ? ph : $urandom_range(1, 6);
            write_gap(GAP_W'(g));
            // long receiver hold-off while a full queue keeps the sender busy
            if (ph == 1) hold_arm = 1'b1;
            target = stim_count + PHASE_WORDS;
            while (stim_count < target) begin
                // sender stops once until every result is back
                if (ph == 2 && !paused && stim_count >= target - PHASE_WORDS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 6) == 0) begin
                    // noise: any code, including the spare ones
                    repeat ($urandom_range(5, 20))
                        push_word(rand_word(3'($urandom_range(0, 7))));
                end else begin
                    queue_poll_run(g);
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && predicted_words.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // stuck handshake guard, far above the slowest legal run
    initial begin : watchdog_proc
        #(8 * 400000);
        $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/ajr_pkg.sv
sv/ajr_in_if.sv
sv/ajr_out_if.sv
sv/auto_joypad_reader_core.sv
tb/sv/tb.sv
